// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off during reset
`define FRMAVG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, switched off during reset
`define FRMAVG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Condition that must hold on the cycle after a reset edge
`define FRMAVG_ASSERT_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

`endif

// ===== hdl/frmavg_pkg.sv =====
// Shared types and constants of the frame rate moving average unit
package frmavg_pkg;

  // Field widths
  localparam int TICK_W  = 32;
  localparam int VALUE_W = 24;
  localparam int COUNT_W = 7;

  // Rate numerator: 1e6 us per second in 20.8 fixed point
  localparam int          FPS_NUM_W     = 28;
  localparam logic [27:0] FPS_NUMERATOR = 28'd256000000;

  // Saturation ceiling shared by interval, mean and rate
  localparam logic [VALUE_W-1:0] VALUE_MAX = 24'hFFFFFF;

  // Divisor width of the shared divider
  localparam int DEN_W = VALUE_W;

  // Divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } frmavg_div_stat_t;

endpackage

// ===== hdl/frmavg_if.sv =====
// Handshake channels: tick input, result output and configuration write
interface frmavg_in_if import frmavg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TICK_W-1:0] tick_time_us;

  modport source (output valid, output tick_time_us, input ready);
  modport sink   (input valid, input tick_time_us, output ready);
endinterface

interface frmavg_out_if import frmavg_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] average_us;
  logic [VALUE_W-1:0] fps_q8;

  modport source (output valid, output average_us, output fps_q8, input ready);
  modport sink   (input valid, input average_us, input fps_q8, output ready);
endinterface

interface frmavg_cfg_if import frmavg_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] average_count;

  modport source (output valid, output average_count, input ready);
  modport sink   (input valid, input average_count, output ready);
endinterface

// ===== hdl/frmavg_divider.sv =====
// Serial restoring divider, one quotient bit per cycle, shared by mean and rate
module frmavg_divider import frmavg_pkg::*; #(
  parameter int NUM_W = 31
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [NUM_W-1:0]       dividend,
  input  logic [DEN_W-1:0]       divisor,
  output logic [NUM_W-1:0]       quotient,
  output frmavg_div_stat_t       stat
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [CNT_W-1:0] bits_left;
  logic             busy;
  logic             done;

  logic [DEN_W:0] shifted;
  logic [DEN_W:0] diff;
  logic           fits;

  // One trial subtraction of the partial remainder
  always_comb begin
    shifted = {rem, quo[NUM_W-1]};
    diff    = shifted - {1'b0, den};
    fits    = (shifted >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      done      <= 1'b0;
      bits_left <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy      <= 1'b1;
        bits_left <= CNT_W'(NUM_W);
      end else if (busy) begin
        bits_left <= bits_left - 1'b1;
        if (bits_left == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: dividend bits shift out as quotient bits shift in
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      quo <= dividend;
      rem <= '0;
      den <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= diff[DEN_W-1:0];
        quo <= {quo[NUM_W-2:0], 1'b1};
      end else begin
        rem <= shifted[DEN_W-1:0];
        quo <= {quo[NUM_W-2:0], 1'b0};
      end
    end
  end

  assign quotient  = quo;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ===== hdl/frame_rate_moving_average_unit.sv =====
// Steps per tick: check, drop of the oldest interval (up to 2 drops, each followed by a new check),
// ring write, mean division, rate division, done; a zero mean skips the rate division.
// Divisions run on the shared serial divider, one quotient bit a cycle, NW = max(24+clog2(MAX_WINDOW+1), 28).
// Input not ready while a tick is at work, so a new tick waits until the last is through; a word left
// waiting in the output register holds the next tick at its end until it is taken.
// Reset clears timestamp, slot, fill count, sum, count (64, capped); the ring is not cleared.
module frame_rate_moving_average_unit import frmavg_pkg::*; #(
  parameter int MAX_WINDOW = 64
) (
  input  logic          clk,
  input  logic          rst,
  frmavg_in_if.sink     tick,
  frmavg_out_if.source  result,
  frmavg_cfg_if.sink    cfg
);

  localparam int FW        = $clog2(MAX_WINDOW + 1);
  localparam int SW        = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int IW        = FW + 1;
  localparam int TW        = VALUE_W + FW;
  localparam int NW        = (TW > FPS_NUM_W) ? TW : FPS_NUM_W;
  localparam int CNT_RESET = (MAX_WINDOW < 64) ? MAX_WINDOW : 64;
  localparam logic [1:0] MAX_DROPS = 2'd2;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CHK   = 9'b000000010,
    S_SUB   = 9'b000000100,
    S_WR    = 9'b000001000,
    S_MGO   = 9'b000010000,
    S_MWAIT = 9'b000100000,
    S_FGO   = 9'b001000000,
    S_FWAIT = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t              state;
  logic [TICK_W-1:0]   previous_time;
  logic [SW-1:0]       write_slot;
  logic [FW-1:0]       fill_count;
  logic [TW-1:0]       window_total;
  logic [FW-1:0]       avg_cnt;
  logic [1:0]          drop_cnt;
  logic [VALUE_W-1:0]  interval;
  logic [VALUE_W-1:0]  mean_val;
  logic [VALUE_W-1:0]  fps_val;
  logic                res_valid;
  logic [VALUE_W-1:0]  res_avg;
  logic [VALUE_W-1:0]  res_fps;

  logic [VALUE_W-1:0]  interval_ring [MAX_WINDOW];
  logic [VALUE_W-1:0]  rd_data;

  logic [TICK_W-1:0]   delta;
  logic [VALUE_W-1:0]  interval_next;
  logic [IW-1:0]       oldest_idx;
  logic                need_drop;
  logic [FW-1:0]       cfg_count;
  logic                div_start;
  logic [NW-1:0]       div_dividend;
  logic [DEN_W-1:0]    div_divisor;
  logic [NW-1:0]       div_quotient;
  frmavg_div_stat_t    div_stat;
  logic [VALUE_W-1:0]  quo_sat;

  // Handshakes
  assign tick.ready = (state == S_IDLE) && !rst;
  assign cfg.ready  = !rst;
  assign result.valid      = res_valid;
  assign result.average_us = res_avg;
  assign result.fps_q8     = res_fps;

  // Wrapping interval, saturated to 24 bits
  always_comb begin
    delta         = tick.tick_time_us - previous_time;
    interval_next = (|delta[TICK_W-1:VALUE_W]) ? VALUE_MAX : delta[VALUE_W-1:0];
  end

  // Slot of the oldest held interval
  always_comb begin
    if (IW'(write_slot) >= IW'(fill_count)) begin
      oldest_idx = IW'(write_slot) - IW'(fill_count);
    end else begin
      oldest_idx = IW'(write_slot) + IW'(MAX_WINDOW) - IW'(fill_count);
    end
    need_drop = (fill_count >= avg_cnt) && (drop_cnt != MAX_DROPS);
  end

  // Count register write, clamped to 1..MAX_WINDOW
  always_comb begin
    if (cfg.average_count == '0) begin
      cfg_count = FW'(1);
    end else if (32'(cfg.average_count) > MAX_WINDOW) begin
      cfg_count = FW'(MAX_WINDOW);
    end else begin
      cfg_count = FW'(cfg.average_count);
    end
  end

  // Divider operands: window sum over count, then numerator over mean
  always_comb begin
    div_start = ((state == S_MGO) || (state == S_FGO)) && !div_stat.busy;
    if (state == S_FGO) begin
      div_dividend = NW'(FPS_NUMERATOR);
      div_divisor  = mean_val;
    end else begin
      div_dividend = NW'(window_total);
      div_divisor  = DEN_W'(fill_count);
    end
    quo_sat = (div_quotient > NW'(VALUE_MAX)) ? VALUE_MAX : div_quotient[VALUE_W-1:0];
  end

  frmavg_divider #(
    .NUM_W (NW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quotient),
    .stat     (div_stat)
  );

  // Interval ring, registered read
  always_ff @(posedge clk) begin
    if (state == S_WR) begin
      interval_ring[write_slot] <= interval;
    end
    if (state == S_CHK) begin
      rd_data <= interval_ring[oldest_idx[SW-1:0]];
    end
  end

  // Count register
  always_ff @(posedge clk) begin
    if (rst) begin
      avg_cnt <= FW'(CNT_RESET);
    end else if (cfg.valid && cfg.ready) begin
      avg_cnt <= cfg_count;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      previous_time <= '0;
      write_slot    <= '0;
      fill_count    <= '0;
      window_total  <= '0;
      drop_cnt      <= '0;
      res_valid     <= 1'b0;
    end else begin
      // Result word flag: set as a finished tick moves out, cleared when taken
      if ((state == S_DONE) && (!res_valid || result.ready)) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (tick.valid) begin
            interval      <= interval_next;
            previous_time <= tick.tick_time_us;
            drop_cnt      <= '0;
            state         <= S_CHK;
          end
        end
        S_CHK: begin
          if (need_drop) begin
            state <= S_SUB;
          end else begin
            state <= S_WR;
          end
        end
        S_SUB: begin
          window_total <= window_total - TW'(rd_data);
          fill_count   <= fill_count - 1'b1;
          drop_cnt     <= drop_cnt + 1'b1;
          state        <= S_CHK;
        end
        S_WR: begin
          window_total <= window_total + TW'(interval);
          fill_count   <= fill_count + 1'b1;
          if (32'(write_slot) == MAX_WINDOW - 1) begin
            write_slot <= '0;
          end else begin
            write_slot <= write_slot + 1'b1;
          end
          state <= S_MGO;
        end
        S_MGO: begin
          if (!div_stat.busy) begin
            state <= S_MWAIT;
          end
        end
        S_MWAIT: begin
          if (div_stat.done) begin
            mean_val <= quo_sat;
            if (quo_sat == '0) begin
              fps_val <= VALUE_MAX;
              state   <= S_DONE;
            end else begin
              state <= S_FGO;
            end
          end
        end
        S_FGO: begin
          if (!div_stat.busy) begin
            state <= S_FWAIT;
          end
        end
        S_FWAIT: begin
          if (div_stat.done) begin
            fps_val <= quo_sat;
            state   <= S_DONE;
          end
        end
        S_DONE: begin
          if (!res_valid || result.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if ((state == S_DONE) && (!res_valid || result.ready)) begin
      res_avg <= mean_val;
      res_fps <= fps_val;
    end
  end

endmodule

// ===== hdl/frmavg_checker.sv =====
// Port-level checker for the frame rate moving average unit, with its bind
`include "assert_macros.svh"

module frmavg_checker import frmavg_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               tick_valid,
  input logic               tick_ready,
  input logic               res_valid,
  input logic               res_ready,
  input logic [VALUE_W-1:0] res_avg,
  input logic [VALUE_W-1:0] res_fps
);

  // A stalled result word holds its value
  `FRMAVG_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_avg) && $stable(res_fps), "result word changed while stalled")

  // A taken tick keeps the input closed on the next cycle
  `FRMAVG_ASSERT_NXT(a_busy_after_tick, tick_valid && tick_ready, !tick_ready, "input ready straight after a tick")

  // A zero mean reports the top rate
  `FRMAVG_ASSERT_IMP(a_zero_mean_rate, res_valid && (res_avg == '0), res_fps == VALUE_MAX, "zero mean without top rate")

  // Reset leaves no result word pending
  `FRMAVG_ASSERT_RST(a_reset_empty, !res_valid, "result word pending after reset")

endmodule

bind frame_rate_moving_average_unit frmavg_checker u_frmavg_checker (
  .clk        (clk),
  .rst        (rst),
  .tick_valid (tick.valid),
  .tick_ready (tick.ready),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .res_avg    (result.average_us),
  .res_fps    (result.fps_q8)
);
